### rtl/udp_tte_pkg.sv
// types, codes and symbol match functions for the udp truth table evaluator
package udp_tte_pkg;

  typedef logic [1:0] val_t;
  typedef logic [3:0] sym_t;

  // operation codes
  localparam logic [2:0] OP_WR_SYMBOL = 3'd0;
  localparam logic [2:0] OP_WR_TAIL   = 3'd1;
  localparam logic [2:0] OP_EVAL_LVL  = 3'd2;
  localparam logic [2:0] OP_EVAL_EDGE = 3'd3;
  localparam logic [2:0] OP_RELOAD    = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_SEQUENTIAL  = 3'd0;
  localparam logic [2:0] REG_INIT_DECL   = 3'd1;
  localparam logic [2:0] REG_INIT_OUTPUT = 3'd2;
  localparam logic [2:0] REG_ROW_COUNT   = 3'd3;
  localparam logic [2:0] REG_INPUT_COUNT = 3'd4;

  // three-valued signal codes
  localparam val_t V_ZERO = 2'd0;
  localparam val_t V_ONE  = 2'd1;
  localparam val_t V_X    = 2'd2;
  localparam val_t V_BAD  = 2'd3;

  // table symbol codes
  localparam sym_t S_ZERO  = 4'd0;
  localparam sym_t S_ONE   = 4'd1;
  localparam sym_t S_X     = 4'd2;
  localparam sym_t S_ANY   = 4'd3;
  localparam sym_t S_BIN   = 4'd4;
  localparam sym_t S_RISE  = 4'd5;
  localparam sym_t S_FALL  = 4'd6;
  localparam sym_t S_POS   = 4'd7;
  localparam sym_t S_NEG   = 4'd8;
  localparam sym_t S_STAR  = 4'd9;
  localparam sym_t S_PAREN = 4'd10;

  // row output code that keeps the held value
  localparam val_t OUT_KEEP = 2'd3;

  // unused state column
  localparam logic [2:0] ST_NONE = 3'd0;

  // width of one stored symbol entry: symbol, from level, to level
  localparam int SymEntW = 10;
  localparam int TailW   = 5;

  function automatic val_t norm_val(input val_t v);
    return (v == V_BAD) ? V_X : v;
  endfunction

  function automatic logic lvl_match(input sym_t s, input val_t v);
    logic m;
    unique case (s)
      S_ZERO:  m = (v == V_ZERO);
      S_ONE:   m = (v == V_ONE);
      S_X:     m = (v == V_X);
      S_ANY:   m = 1'b1;
      S_BIN:   m = (v == V_ZERO) || (v == V_ONE);
      default: m = 1'b0;
    endcase
    return m;
  endfunction

  function automatic logic is_edge_sym(input sym_t s);
    return (s >= S_RISE) && (s <= S_PAREN);
  endfunction

  function automatic logic edge_match(input sym_t s, input val_t p, input val_t c,
                                      input logic [2:0] from_lvl, input logic [2:0] to_lvl);
    logic m;
    unique case (s)
      S_RISE:  m = (p == V_ZERO) && (c == V_ONE);
      S_FALL:  m = (p == V_ONE) && (c == V_ZERO);
      S_POS:   m = ((p == V_ZERO) && (c == V_ONE)) || ((p == V_ZERO) && (c == V_X)) ||
                   ((p == V_X) && (c == V_ONE));
      S_NEG:   m = ((p == V_ONE) && (c == V_ZERO)) || ((p == V_ONE) && (c == V_X)) ||
                   ((p == V_X) && (c == V_ZERO));
      S_STAR:  m = (p != c);
      S_PAREN: m = lvl_match({1'b0, from_lvl}, p) && lvl_match({1'b0, to_lvl}, c);
      default: m = 1'b0;
    endcase
    return m;
  endfunction

endpackage

### rtl/udp_truth_table_evaluator.sv
// top level of the udp truth table evaluator: table memories, row scan and output
//
// evaluates a user-defined-primitive truth table over 0/1/x signals. the
// table lives in two synchronous memories, each with one write port and
// one read port: one row-wide symbol memory (one 10-bit entry per input
// column, written one column at a time) and one row tail memory (state and
// output symbol). every transaction on the input channel yields exactly one
// result transaction. table writes, reload, unknown operations and
// evaluations of an empty table go from accept straight to the done state
// without a scan. an evaluation reads one row per cycle, compares all
// columns in parallel and goes to the done state once a row decides the
// result or the last row is checked. the result then moves from the done
// state to the output register; while that is stalled, the block waits.
// a level evaluation stops at the first matching row; an edge evaluation
// stops at the first matching row without edge symbols, otherwise scans
// every row. the block works on one transaction at a time; a new one is
// taken as soon as the previous result is parked in the output register.
// configuration may be written only while no transaction is in flight.
// table entries are not cleared at reset and must be written before use.
module udp_truth_table_evaluator import udp_tte_pkg::*; #(
  parameter int MAX_INPUTS = 10,
  parameter int MAX_ROWS   = 64
) (
  input  logic        clk,
  input  logic        rst,

  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data,

  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [5:0]  row_index,
  input  logic [3:0]  column,
  input  logic [3:0]  input_symbol,
  input  logic [2:0]  paren_from,
  input  logic [2:0]  paren_to,
  input  logic [2:0]  state_symbol,
  input  logic [1:0]  output_symbol,
  input  logic [19:0] input_values,
  input  logic [3:0]  changed_index,
  input  logic [1:0]  previous_value,

  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  output_value,
  output logic        no_match
);

  localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ColW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int CntW = $clog2(MAX_ROWS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef logic [MAX_INPUTS-1:0][SymEntW-1:0] sym_row_t;

  state_t state;

  // configuration registers
  logic       sequential;
  logic       init_decl;
  logic [1:0] initial_output;
  logic [6:0] row_count;
  logic [3:0] input_count;

  // primitive output kept between evaluations
  val_t held_output;

  // latched evaluation operands
  logic [2:0]  op_q;
  logic [19:0] vals_q;
  logic [3:0]  chg_q;
  val_t        prev_q;

  // scan control
  logic [CntW-1:0] issue_cnt;
  logic            pend;
  logic            ed_found;
  val_t            ed_res;

  // result waiting to move to the output register
  val_t res_val;
  logic res_nm;

  // memories
  sym_row_t         sym_mem [MAX_ROWS];
  logic [TailW-1:0] tail_mem [MAX_ROWS];
  sym_row_t         sym_q;
  logic [TailW-1:0] tail_q;

  logic [RowW-1:0] rd_addr;
  logic [RowW-1:0] wr_row;
  logic [ColW-1:0] wr_col;
  logic            row_ok_wr;
  logic            col_ok_wr;
  logic            accept;

  logic [CntW-1:0] scan_rows;
  logic [3:0]      scan_cols;

  // row compare results
  logic [MAX_INPUTS-1:0] col_ok;
  logic [MAX_INPUTS-1:0] col_edge;
  logic                  state_ok;
  logic                  row_hit;
  logic                  row_edge;
  val_t                  row_res;
  logic                  lv_hit;
  logic                  ed_new;
  logic                  last_row;
  val_t                  reload_val;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // clamp table dimensions to the storage that exists
  assign scan_rows = (int'(row_count) > MAX_ROWS) ? CntW'(MAX_ROWS) : CntW'(row_count);
  assign scan_cols = (int'(input_count) > MAX_INPUTS) ? 4'(MAX_INPUTS) : input_count;

  assign rd_addr   = issue_cnt[RowW-1:0];
  assign wr_row    = RowW'(row_index);
  assign wr_col    = ColW'(column);
  assign row_ok_wr = int'(row_index) < MAX_ROWS;
  assign col_ok_wr = int'(column) < MAX_INPUTS;

  // symbol memory: one column written per transaction, one row read per cycle
  always_ff @(posedge clk) begin
    if (accept && (operation == OP_WR_SYMBOL) && row_ok_wr && col_ok_wr) begin
      sym_mem[wr_row][wr_col] <= {paren_to, paren_from, input_symbol};
    end
    sym_q <= sym_mem[rd_addr];
  end

  // row tail memory
  always_ff @(posedge clk) begin
    if (accept && (operation == OP_WR_TAIL) && row_ok_wr) begin
      tail_mem[wr_row] <= {output_symbol, state_symbol};
    end
    tail_q <= tail_mem[rd_addr];
  end

  // compare every column of the row just read
  always_comb begin
    sym_t       s;
    val_t       c;
    logic [2:0] fl;
    logic [2:0] tl;
    for (int i = 0; i < MAX_INPUTS; i++) begin
      s  = sym_q[i][3:0];
      fl = sym_q[i][6:4];
      tl = sym_q[i][9:7];
      c  = norm_val(vals_q[2*i +: 2]);
      if (4'(i) >= scan_cols) begin
        col_ok[i]   = 1'b1;
        col_edge[i] = 1'b0;
      end else if (is_edge_sym(s)) begin
        col_edge[i] = 1'b1;
        col_ok[i]   = (op_q == OP_EVAL_EDGE) && (chg_q == 4'(i)) &&
                      edge_match(s, prev_q, c, fl, tl);
      end else begin
        col_edge[i] = 1'b0;
        col_ok[i]   = lvl_match(s, c);
      end
    end
  end

  // state column check against the held output
  always_comb begin
    logic [2:0] st;
    st = tail_q[2:0];
    if (!sequential || (st == ST_NONE)) begin
      state_ok = 1'b1;
    end else begin
      state_ok = lvl_match({1'b0, st - 3'd1}, held_output);
    end
  end

  assign row_hit  = (&col_ok) && state_ok;
  assign row_edge = |col_edge;
  assign row_res  = (tail_q[4:3] == OUT_KEEP) ? held_output : tail_q[4:3];
  assign lv_hit   = pend && row_hit && !row_edge;
  assign ed_new   = pend && row_hit && row_edge && !ed_found;
  assign last_row = pend && (issue_cnt == scan_rows);

  assign reload_val = (sequential && init_decl && (initial_output != V_BAD)) ?
                      initial_output : V_X;

  // control, configuration, held output and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      sequential     <= 1'b0;
      init_decl      <= 1'b0;
      initial_output <= V_X;
      row_count      <= 7'd0;
      input_count    <= 4'd1;
      held_output    <= V_X;
      out_valid      <= 1'b0;
      issue_cnt      <= '0;
      pend           <= 1'b0;
      ed_found       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_SEQUENTIAL:  sequential     <= cfg_data[0];
          REG_INIT_DECL:   init_decl      <= cfg_data[0];
          REG_INIT_OUTPUT: initial_output <= cfg_data[1:0];
          REG_ROW_COUNT:   row_count      <= cfg_data;
          REG_INPUT_COUNT: input_count    <= cfg_data[3:0];
          default: ;
        endcase
      end

      // output register frees up when the consumer takes the transaction,
      // unless a new result moves in at the same edge
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_q      <= operation;
            vals_q    <= input_values;
            chg_q     <= changed_index;
            prev_q    <= norm_val(previous_value);
            issue_cnt <= '0;
            pend      <= 1'b0;
            ed_found  <= 1'b0;
            if ((operation == OP_EVAL_LVL) || (operation == OP_EVAL_EDGE)) begin
              if (scan_rows == '0) begin
                // empty table never matches
                res_val <= V_X;
                res_nm  <= 1'b1;
                state   <= ST_DONE;
              end else begin
                state <= ST_SCAN;
              end
            end else if (operation == OP_RELOAD) begin
              res_val <= reload_val;
              res_nm  <= 1'b0;
              state   <= ST_DONE;
            end else begin
              // writes and unknown operations report the held output
              res_val <= held_output;
              res_nm  <= 1'b0;
              state   <= ST_DONE;
            end
          end
        end

        ST_SCAN: begin
          if (issue_cnt != scan_rows) begin
            issue_cnt <= issue_cnt + CntW'(1);
          end
          pend <= 1'b1;
          if (ed_new) begin
            ed_found <= 1'b1;
            ed_res   <= row_res;
          end
          if (lv_hit) begin
            // a level row wins over any edge row
            res_val <= row_res;
            res_nm  <= 1'b0;
            state   <= ST_DONE;
          end else if (last_row) begin
            if (ed_found) begin
              res_val <= ed_res;
              res_nm  <= 1'b0;
            end else if (ed_new) begin
              res_val <= row_res;
              res_nm  <= 1'b0;
            end else begin
              res_val <= V_X;
              res_nm  <= 1'b1;
            end
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!out_valid || out_ready) begin
            held_output  <= res_val;
            output_value <= res_val;
            no_match     <= res_nm;
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### bench/udp_truth_table_evaluator_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the udp truth table evaluator: directed and random transactions
module udp_truth_table_evaluator_test import udp_tte_pkg::*;;

  localparam int NumInputs = 10;
  localparam int NumRows   = 64;
  localparam int PhaseOps  = 32;    // seven random phases; with the table fill about 950
  localparam int TailWait  = 80;    // a full scan plus the output register
  localparam int MaxReports = 10;

  // one input transaction, field by field
  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  row;
    logic [3:0]  col;
    sym_t        sym;
    logic [2:0]  from_lvl;
    logic [2:0]  to_lvl;
    logic [2:0]  state;
    logic [1:0]  outsym;
    logic [19:0] values;
    logic [3:0]  changed;
    val_t        prev;
  } udp_op_t;

  // one result transaction
  typedef struct packed {
    val_t value;
    logic miss;
  } udp_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation = '0;
  logic [5:0]  row_index = '0;
  logic [3:0]  column = '0;
  logic [3:0]  input_symbol = '0;
  logic [2:0]  paren_from = '0;
  logic [2:0]  paren_to = '0;
  logic [2:0]  state_symbol = '0;
  logic [1:0]  output_symbol = '0;
  logic [19:0] input_values = '0;
  logic [3:0]  changed_index = '0;
  logic [1:0]  previous_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  output_value;
  logic        no_match;

  udp_truth_table_evaluator dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .row_index      (row_index),
    .column         (column),
    .input_symbol   (input_symbol),
    .paren_from     (paren_from),
    .paren_to       (paren_to),
    .state_symbol   (state_symbol),
    .output_symbol  (output_symbol),
    .input_values   (input_values),
    .changed_index  (changed_index),
    .previous_value (previous_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .output_value   (output_value),
    .no_match       (no_match)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // pending input transactions and the outputs they should produce
  udp_op_t  pending_ops[$];
  udp_out_t expected_outputs[$];
  udp_op_t  drive_op = '0;
  logic     in_taken = 1'b0;
  int       send_idle = 0;
  int       recv_idle = 0;
  int       mismatches = 0;

  // shadow of the configuration registers, reset values
  logic       cfg_seq = 1'b0;
  logic       cfg_has_init = 1'b0;
  val_t       cfg_init = V_X;
  logic [6:0] cfg_rows = '0;
  logic [3:0] cfg_inputs = 4'd1;

  // shadow of the table and the held output
  logic [9:0] symbol_mem [NumRows*NumInputs];
  logic [4:0] tail_mem [NumRows];
  val_t       held = V_X;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // level symbol against a 0/1/x value; anything else never matches
  function automatic logic level_hit(input sym_t s, input val_t v);
    case (s)
      S_ZERO:  return v == V_ZERO;
      S_ONE:   return v == V_ONE;
      S_X:     return v == V_X;
      S_ANY:   return 1'b1;
      S_BIN:   return v == V_ZERO || v == V_ONE;
      default: return 1'b0;
    endcase
  endfunction

  // edge symbol against the transition prev -> cur of the changed input
  function automatic logic edge_hit(input logic [9:0] ent, input val_t p, input val_t c);
    case (ent[3:0])
      S_RISE:  return p == V_ZERO && c == V_ONE;
      S_FALL:  return p == V_ONE && c == V_ZERO;
      S_POS:   return (p == V_ZERO && c == V_ONE) || (p == V_ZERO && c == V_X) ||
                      (p == V_X && c == V_ONE);
      S_NEG:   return (p == V_ONE && c == V_ZERO) || (p == V_ONE && c == V_X) ||
                      (p == V_X && c == V_ZERO);
      S_STAR:  return p != c;
      S_PAREN: return level_hit({1'b0, ent[6:4]}, p) && level_hit({1'b0, ent[9:7]}, c);
      default: return 1'b0;
    endcase
  endfunction

  // value of input i, code 3 read as x
  function automatic val_t value_at(input logic [19:0] vals, input int i);
    val_t v;
    v = vals[2*i +: 2];
    return (v == V_BAD) ? V_X : v;
  endfunction

  // current-state column; ignored for combinational tables or an empty column
  function automatic logic state_hit(input logic [4:0] tail);
    logic [2:0] s;
    s = tail[2:0];
    if (!cfg_seq || s == ST_NONE) return 1'b1;
    return level_hit({1'b0, s} - 4'd1, held);
  endfunction

  function automatic val_t tail_output(input logic [4:0] tail);
    return (tail[4:3] == OUT_KEEP) ? held : tail[4:3];
  endfunction

  // apply one transaction to the shadow state, return the result it causes
  task automatic udp_evaluate(input udp_op_t t, output val_t value, output logic miss);
    int         rows;
    int         cols;
    int         r;
    int         i;
    logic       ok;
    logic       edge_row;
    logic       level_found;
    logic       edge_found;
    val_t       level_res;
    val_t       edge_res;
    val_t       pv;
    val_t       cv;
    logic [9:0] ent;
    rows = (cfg_rows > NumRows) ? NumRows : cfg_rows;
    cols = (cfg_inputs > NumInputs) ? NumInputs : cfg_inputs;
    miss = 1'b0;
    level_found = 1'b0;
    edge_found = 1'b0;
    level_res = V_ZERO;
    edge_res = V_ZERO;
    pv = (t.prev == V_BAD) ? V_X : t.prev;
    case (t.op)
      OP_WR_SYMBOL: begin
        // columns past the last input are dropped
        if (t.col < NumInputs)
          symbol_mem[t.row * NumInputs + t.col] = {t.to_lvl, t.from_lvl, t.sym};
      end
      OP_WR_TAIL: begin
        tail_mem[t.row] = {t.outsym, t.state};
      end
      OP_EVAL_LVL: begin
        // first matching row wins, edge symbols never match as levels
        for (r = 0; r < rows && !level_found; r++) begin
          ok = 1'b1;
          for (i = 0; i < cols && ok; i++)
            ok = level_hit(symbol_mem[r*NumInputs + i][3:0], value_at(t.values, i));
          if (ok && state_hit(tail_mem[r])) begin
            held = tail_output(tail_mem[r]);
            level_found = 1'b1;
          end
        end
        if (!level_found) begin
          held = V_X;
          miss = 1'b1;
        end
      end
      OP_EVAL_EDGE: begin
        // first pure-level row beats first edge row; edges only in the changed column
        for (r = 0; r < rows; r++) begin
          ok = 1'b1;
          edge_row = 1'b0;
          for (i = 0; i < cols && ok; i++) begin
            ent = symbol_mem[r*NumInputs + i];
            cv = value_at(t.values, i);
            if (ent[3:0] >= S_RISE && ent[3:0] <= S_PAREN) begin
              edge_row = 1'b1;
              ok = (i == t.changed) && edge_hit(ent, pv, cv);
            end else begin
              ok = level_hit(ent[3:0], cv);
            end
          end
          if (ok && state_hit(tail_mem[r])) begin
            if (edge_row && !edge_found) begin
              edge_found = 1'b1;
              edge_res = tail_output(tail_mem[r]);
            end
            if (!edge_row && !level_found) begin
              level_found = 1'b1;
              level_res = tail_output(tail_mem[r]);
            end
          end
        end
        if (level_found) held = level_res;
        else if (edge_found) held = edge_res;
        else begin
          held = V_X;
          miss = 1'b1;
        end
      end
      OP_RELOAD: begin
        held = (cfg_seq && cfg_has_init && cfg_init != V_BAD) ? cfg_init : V_X;
      end
      default: ;
    endcase
    value = held;
  endtask

  // ---------------------------------------------------------------------------
  // driver: one transaction from the pending queue, changed on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      // hold the payload until the transaction is taken
      if (!in_valid || in_taken) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle) begin
          drive_op = pending_ops.pop_front();
          operation <= drive_op.op;
          row_index <= drive_op.row;
          column <= drive_op.col;
          input_symbol <= drive_op.sym;
          paren_from <= drive_op.from_lvl;
          paren_to <= drive_op.to_lvl;
          state_symbol <= drive_op.state;
          output_symbol <= drive_op.outsym;
          input_values <= drive_op.values;
          changed_index <= drive_op.changed;
          previous_value <= drive_op.prev;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on input accept, checks on output accept
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    udp_out_t want;
    val_t     pv;
    logic     pm;
    in_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      // check first: a result always belongs to an earlier transaction
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          if (mismatches < MaxReports)
            $display("unexpected result: output_value %0d no_match %0b",
                     output_value, no_match);
          mismatches++;
        end else begin
          want = expected_outputs.pop_front();
          if (output_value !== want.value || no_match !== want.miss) begin
            if (mismatches < MaxReports)
              $display("mismatch: expected output_value %0d no_match %0b, got %0d %0b",
                       want.value, want.miss, output_value, no_match);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        udp_evaluate(drive_op, pv, pm);
        expected_outputs.push_back('{value: pv, miss: pm});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_op(input logic [2:0] op, input logic [5:0] row, input logic [3:0] col,
                          input sym_t sym, input logic [2:0] pf, input logic [2:0] pt,
                          input logic [2:0] st, input logic [1:0] os,
                          input logic [19:0] vals, input logic [3:0] chg, input val_t prev);
    pending_ops.push_back('{op: op, row: row, col: col, sym: sym, from_lvl: pf, to_lvl: pt,
                            state: st, outsym: os, values: vals, changed: chg, prev: prev});
  endtask

  // mostly level symbols, a fair share of edges, a few undefined codes
  function automatic sym_t pick_symbol();
    int w;
    w = $urandom_range(99);
    if (w < 30) return S_ANY;
    if (w < 45) return S_BIN;
    if (w < 58) return S_ZERO;
    if (w < 71) return S_ONE;
    if (w < 76) return S_X;
    if (w < 95) return S_RISE + sym_t'($urandom_range(S_PAREN - S_RISE));
    return S_PAREN + 4'd1 + sym_t'($urandom_range(4));
  endfunction

  // paren levels, sometimes out of the defined range
  function automatic logic [2:0] pick_level();
    if ($urandom_range(99) < 90) return 3'($urandom_range(S_BIN));
    return 3'($urandom_range(7));
  endfunction

  function automatic logic [19:0] pick_values();
    logic [19:0] vals;
    int          w;
    int          i;
    for (i = 0; i < NumInputs; i++) begin
      w = $urandom_range(99);
      vals[2*i +: 2] = (w < 40) ? V_ZERO : (w < 80) ? V_ONE : (w < 94) ? V_X : V_BAD;
    end
    return vals;
  endfunction

  // random transaction shaped by the current setting: most hit rows and columns in use
  function automatic udp_op_t random_op();
    udp_op_t t;
    int      w;
    int      ncol;
    int      nrow;
    ncol = (cfg_inputs == 0) ? 1 : (cfg_inputs > NumInputs) ? NumInputs : cfg_inputs;
    nrow = (cfg_rows == 0) ? NumRows : (cfg_rows > NumRows) ? NumRows : cfg_rows;
    t.op = 3'($urandom_range(7));
    t.row = 6'($urandom_range(63));
    t.col = 4'($urandom_range(15));
    t.sym = 4'($urandom_range(15));
    t.from_lvl = 3'($urandom_range(7));
    t.to_lvl = 3'($urandom_range(7));
    t.state = 3'($urandom_range(7));
    t.outsym = 2'($urandom_range(3));
    t.values = 20'($urandom);
    t.changed = 4'($urandom_range(15));
    t.prev = 2'($urandom_range(3));
    w = $urandom_range(99);
    if (w < 15) begin
      t.op = OP_WR_SYMBOL;
      if ($urandom_range(99) < 80) t.row = 6'($urandom_range(nrow - 1));
      if ($urandom_range(99) < 90) t.col = 4'($urandom_range(ncol - 1));
      t.sym = pick_symbol();
      t.from_lvl = pick_level();
      t.to_lvl = pick_level();
    end else if (w < 23) begin
      t.op = OP_WR_TAIL;
      if ($urandom_range(99) < 80) t.row = 6'($urandom_range(nrow - 1));
      if ($urandom_range(99) < 90) t.state = 3'($urandom_range(5));
    end else if (w < 58) begin
      t.op = OP_EVAL_LVL;
      t.values = pick_values();
    end else if (w < 93) begin
      t.op = OP_EVAL_EDGE;
      t.values = pick_values();
      if ($urandom_range(99) < 90) t.changed = 4'($urandom_range(ncol - 1));
    end else if (w < 97) begin
      t.op = OP_RELOAD;
    end else begin
      t.op = OP_RELOAD + 3'd1 + 3'($urandom_range(2));
    end
    return t;
  endfunction

  // register write on the falling edge, only while the block is idle
  task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SEQUENTIAL:  cfg_seq = val[0];
      REG_INIT_DECL:   cfg_has_init = val[0];
      REG_INIT_OUTPUT: cfg_init = val[1:0];
      REG_ROW_COUNT:   cfg_rows = val;
      REG_INPUT_COUNT: cfg_inputs = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(input logic seq, input logic has_init, input val_t init,
                            input logic [6:0] rows, input logic [3:0] inputs);
    write_reg(REG_SEQUENTIAL, {6'd0, seq});
    write_reg(REG_INIT_DECL, {6'd0, has_init});
    write_reg(REG_INIT_OUTPUT, {5'd0, init});
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_INPUT_COUNT, {3'd0, inputs});
  endtask

  // sender holds off until every queued transaction has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_outputs.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int p;
    int k;
    int r;
    int c;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    send_idle = 9;
    recv_idle = 52;
    set_config(1'b1, 1'b1, V_ZERO, 7'd4, 4'd2);

    // write every table entry once so no evaluation ever reads an unwritten one
    for (r = 0; r < NumRows; r++) begin
      for (c = 0; c < NumInputs; c++)
        queue_op(OP_WR_SYMBOL, 6'(r), 4'(c), pick_symbol(), pick_level(), pick_level(),
                 ST_NONE, V_ZERO, '0, '0, V_ZERO);
      queue_op(OP_WR_TAIL, 6'(r), '0, S_ZERO, '0, '0, 3'($urandom_range(5)),
               2'($urandom_range(3)), '0, '0, V_ZERO);
    end
    wait_idle();

    // directed: small two-input sequential table
    queue_op(OP_RELOAD, '0, '0, S_ZERO, '0, '0, ST_NONE, V_ZERO, '0, '0, V_ZERO);
    // row 0: rising edge on input 0, any state, output 1
    queue_op(OP_WR_SYMBOL, 6'd0, 4'd0, S_RISE, '0, '0, ST_NONE, V_ZERO, '0, '0, V_ZERO);
    queue_op(OP_WR_SYMBOL, 6'd0, 4'd1, S_ANY, '0, '0, ST_NONE, V_ZERO, '0, '0, V_ZERO);
    queue_op(OP_WR_TAIL, 6'd0, '0, S_ZERO, '0, '0, 3'd4, V_ONE, '0, '0, V_ZERO);
    // row 1: pure level row, no state column
    queue_op(OP_WR_SYMBOL, 6'd1, 4'd0, S_ZERO, '0, '0, ST_NONE, V_ZERO, '0, '0, V_ZERO);
    queue_op(OP_WR_SYMBOL, 6'd1, 4'd1, S_BIN, '0, '0, ST_NONE, V_ZERO, '0, '0, V_ZERO);
    queue_op(OP_WR_TAIL, 6'd1, '0, S_ZERO, '0, '0, ST_NONE, V_ZERO, '0, '0, V_ZERO);
    // row 2: keeps the held value when it is 1
    queue_op(OP_WR_SYMBOL, 6'd2, 4'd0, S_ANY, '0, '0, ST_NONE, V_ZERO, '0, '0, V_ZERO);
    queue_op(OP_WR_SYMBOL, 6'd2, 4'd1, S_X, '0, '0, ST_NONE, V_ZERO, '0, '0, V_ZERO);
    queue_op(OP_WR_TAIL, 6'd2, '0, S_ZERO, '0, '0, 3'd2, OUT_KEEP, '0, '0, V_ZERO);
    // row 3: parenthesized edge 0 -> ?, binary state, output x
    queue_op(OP_WR_SYMBOL, 6'd3, 4'd0, S_PAREN, 3'(S_ZERO), 3'(S_ANY), ST_NONE, V_ZERO,
             '0, '0, V_ZERO);
    queue_op(OP_WR_SYMBOL, 6'd3, 4'd1, S_ANY, '0, '0, ST_NONE, V_ZERO, '0, '0, V_ZERO);
    queue_op(OP_WR_TAIL, 6'd3, '0, S_ZERO, '0, '0, 3'd5, V_X, '0, '0, V_ZERO);
    // evaluations over the table above
    queue_op(OP_EVAL_LVL, '0, '0, S_ZERO, '0, '0, ST_NONE, V_ZERO, '0, '0, V_ZERO);
    queue_op(OP_EVAL_EDGE, '0, '0, S_ZERO, '0, '0, ST_NONE, V_ZERO, {16'd0, V_ZERO, V_ONE},
             4'd0, V_ZERO);
    queue_op(OP_EVAL_LVL, '0, '0, S_ZERO, '0, '0, ST_NONE, V_ZERO, {16'd0, V_X, V_ONE},
             '0, V_ZERO);
    // all-ones inputs read as x everywhere
    queue_op(OP_EVAL_LVL, '0, '0, S_ZERO, '0, '0, ST_NONE, V_ZERO, 20'hfffff, '0, V_ZERO);
    // changed index out of range: edge rows never match
    queue_op(OP_EVAL_EDGE, '0, '0, S_ZERO, '0, '0, ST_NONE, V_ZERO, {16'd0, V_ZERO, V_ONE},
             4'd15, V_ZERO);
    // previous value code 3 taken as x
    queue_op(OP_EVAL_EDGE, '0, '0, S_ZERO, '0, '0, ST_NONE, V_ZERO, {16'd0, V_ONE, V_ONE},
             4'd0, V_BAD);
    queue_op(OP_EVAL_LVL, '0, '0, S_ZERO, '0, '0, ST_NONE, V_ZERO, '0, '0, V_ZERO);
    // writes that are dropped or land outside the scanned rows
    queue_op(OP_WR_SYMBOL, 6'd1, 4'd12, S_ZERO, '0, '0, ST_NONE, V_ZERO, '0, '0, V_ZERO);
    queue_op(OP_WR_SYMBOL, 6'd5, 4'd0, 4'hf, 3'd7, 3'd7, ST_NONE, V_ZERO, '0, '0, V_ZERO);
    queue_op(OP_WR_TAIL, 6'd63, '0, S_ZERO, '0, '0, 3'd7, OUT_KEEP, '0, '0, V_ZERO);
    queue_op(OP_RELOAD + 3'd3, '0, '0, S_ZERO, '0, '0, ST_NONE, V_ZERO, '0, '0, V_ZERO);
    // level row beats a matching edge row
    queue_op(OP_EVAL_EDGE, '0, '0, S_ZERO, '0, '0, ST_NONE, V_ZERO, {16'd0, V_ONE, V_ZERO},
             4'd0, V_ZERO);
    wait_idle();

    // random phases, each under its own setting
    for (p = 0; p < 7; p++) begin
      case (p)
        0: set_config(1'b1, 1'b1, V_ZERO, 7'd8, 4'd3);
        1: set_config(1'b0, 1'b0, V_X, 7'd64, 4'd10);
        2: set_config(1'b1, 1'b1, V_ONE, 7'd127, 4'd4);
        3: set_config(1'b1, 1'b0, V_BAD, 7'd1, 4'd1);
        4: set_config(1'b1, 1'b1, V_BAD, 7'd16, 4'd0);
        5: set_config(1'b0, 1'b1, V_ONE, 7'd0, 4'd15);
        default: set_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                            2'($urandom_range(3)), 7'($urandom_range(127)),
                            4'($urandom_range(15)));
      endcase
      // sender idles lightly first, then the receiver, then neither
      if (p < 2) begin
        send_idle = 9;
        recv_idle = 52;
      end else if (p < 4) begin
        send_idle = 52;
        recv_idle = 9;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (k = 0; k < PhaseOps; k++)
        pending_ops.push_back(random_op());
      wait_idle();
    end

    // let any stray result show up before deciding
    repeat (TailWait) @(negedge clk);
    if (expected_outputs.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin : watchdog
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
rtl/udp_tte_pkg.sv
rtl/udp_truth_table_evaluator.sv
bench/udp_truth_table_evaluator_test.sv
